/* sv/cblp_pkg.sv */
// shared constants, beat structs and shared-unit command types for the lattice pricer
package cblp_pkg;

	localparam int MAX_STEPS = 256;
	localparam int PRICE_W   = 32;
	localparam int STEP_W    = 9;
	localparam int ROW_DEPTH = MAX_STEPS + 1;
	localparam int ADDR_W    = $clog2(ROW_DEPTH);
	localparam int MUL_W     = 32;
	localparam int POW_W     = 2 * MUL_W;
	localparam int ACC_W     = 3 * MUL_W;
	localparam int SHF_W     = ACC_W - 16;
	localparam int PH_W      = 4;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [POW_W-1:0] ONE_Q30 = POW_W'(64'h4000_0000);

	localparam logic [CFG_W-1:0] UP_RST   = 32'h4000_0000;
	localparam logic [CFG_W-1:0] DOWN_RST = 32'h4000_0000;
	localparam logic [CFG_W-1:0] PAR_RST  = 32'd6553600;
	localparam logic [CFG_W-1:0] CONV_RST = 32'd65536;
	localparam logic [CFG_W-1:0] CALL_RST = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_FACTOR       = 3'd0,
		REG_DOWN_FACTOR     = 3'd1,
		REG_WEIGHT_UP       = 3'd2,
		REG_WEIGHT_DOWN     = 3'd3,
		REG_RECOVERY_TERM   = 3'd4,
		REG_PAR_AMOUNT      = 3'd5,
		REG_CONVERSION_RATIO = 3'd6,
		REG_CALL_PRICE      = 3'd7
	} cfg_idx_t;

	// right shift applied when a product is taken out of the accumulator
	typedef enum logic [1:0] {
		SH_16 = 2'd0,
		SH_30 = 2'd1,
		SH_31 = 2'd2
	} shift_t;

	typedef struct packed {
		logic   go;
		logic   add_hi;
		shift_t sh;
		logic   cap64;
	} mul_cmd_t;

	typedef struct packed {
		logic [POW_W-1:0] value;
		logic             ovf;
	} mul_res_t;

	typedef struct packed {
		logic [PRICE_W-1:0] spot_price;
		logic [STEP_W-1:0]  step_count;
	} in_beat_t;

	typedef struct packed {
		logic [PRICE_W-1:0] bond_value;
		logic               saturated;
	} out_beat_t;

endpackage

/* sv/cblp_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module cblp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/cblp_mul_unit.sv */
// shared 32x32 multiplier with 96-bit accumulator, shift-out and saturation
module cblp_mul_unit import cblp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mul_cmd_t         cmd,
	input  logic [MUL_W-1:0] op_a,
	input  logic [MUL_W-1:0] op_b,
	output mul_res_t         res
);

	logic [POW_W-1:0] prod_s1;
	logic             go_s1;
	logic             add_hi_s1;
	logic [ACC_W-1:0] acc_q;
	logic [SHF_W-1:0] shifted;
	logic             over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1     <= 1'b0;
			add_hi_s1 <= 1'b0;
		end else begin
			go_s1     <= cmd.go;
			add_hi_s1 <= cmd.add_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			prod_s1 <= op_a * op_b;
		end
		// upper partial product lands one word up
		if (go_s1) begin
			if (add_hi_s1) begin
				acc_q <= acc_q + {prod_s1, {MUL_W{1'b0}}};
			end else begin
				acc_q <= {{(ACC_W-POW_W){1'b0}}, prod_s1};
			end
		end
	end

	always_comb begin
		case (cmd.sh)
			SH_16:   shifted = SHF_W'(acc_q >> 16);
			SH_30:   shifted = SHF_W'(acc_q >> 30);
			SH_31:   shifted = SHF_W'(acc_q >> 31);
			default: shifted = '0;
		endcase
	end

	assign over = cmd.cap64 ? (|shifted[SHF_W-1:POW_W]) : (|shifted[SHF_W-1:PRICE_W]);

	always_comb begin
		res.ovf = over;
		if (cmd.cap64) begin
			res.value = over ? {POW_W{1'b1}} : shifted[POW_W-1:0];
		end else begin
			res.value = over ? {{(POW_W-PRICE_W){1'b0}}, {PRICE_W{1'b1}}}
			                 : {{(POW_W-PRICE_W){1'b0}}, shifted[PRICE_W-1:0]};
		end
	end

endmodule

/* sv/convertible_bond_lattice_pricer.sv */
// top level: config registers, lattice sequencer, row memories and the shared multiplier
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+----------------------------------
//  in      | in_valid in_ready in_data        | sink      | spot_price, step_count
//  out     | out_valid out_ready out_data     | source    | bond_value, saturated
//  cfg     | cfg_wr_en cfg_index cfg_data     | sink      | one register write per cycle
//
// one request at a time; in_ready is high only while the sequencer is idle
// a request's run time grows with n = min(step_count, 256) and is set by the single
// shared 32x32 multiplier, which serves every power-table entry and every lattice node
// in turn; each interior level also preloads its row head before its nodes
// a finished result sits in the output register; a new request can start meanwhile,
// and only the final hand-over waits for out_ready
// async active-low reset clears control state; the row memories have no reset
module convertible_bond_lattice_pricer import cblp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_POW_INIT  = 6'b000010,
		ST_POW       = 6'b000100,
		ST_LVL_START = 6'b001000,
		ST_NODE      = 6'b010000,
		ST_FINISH    = 6'b100000
	} state_t;

	// power table sub-steps: up word pair, down word pair, take-outs
	localparam logic [PH_W-1:0] PW_U_LO   = 4'd0;
	localparam logic [PH_W-1:0] PW_U_HI   = 4'd1;
	localparam logic [PH_W-1:0] PW_D_LO   = 4'd2;
	localparam logic [PH_W-1:0] PW_D_HI   = 4'd3; // also takes the up power
	localparam logic [PH_W-1:0] PW_D_TAKE = 4'd5;

	// row head preload
	localparam logic [PH_W-1:0] LS_RD   = 4'd0;
	localparam logic [PH_W-1:0] LS_TAKE = 4'd1;

	// node sub-steps
	localparam logic [PH_W-1:0] PH_RD      = 4'd0;
	localparam logic [PH_W-1:0] PH_SD_LO   = 4'd1;
	localparam logic [PH_W-1:0] PH_SD_HI   = 4'd2;
	localparam logic [PH_W-1:0] PH_SD_TAKE = 4'd4;
	localparam logic [PH_W-1:0] PH_SU_LO   = 4'd5;
	localparam logic [PH_W-1:0] PH_SU_HI   = 4'd6;
	localparam logic [PH_W-1:0] PH_SU_TAKE = 4'd8;
	localparam logic [PH_W-1:0] PH_CONV    = 4'd9;
	localparam logic [PH_W-1:0] PH_WUP     = 4'd10;
	localparam logic [PH_W-1:0] PH_WDN     = 4'd11; // also takes the conversion value
	localparam logic [PH_W-1:0] PH_VU      = 4'd12; // leaf nodes write back here
	localparam logic [PH_W-1:0] PH_VD      = 4'd13;
	localparam logic [PH_W-1:0] PH_SUM     = 4'd14;
	localparam logic [PH_W-1:0] PH_WB      = 4'd15;

	// configuration registers
	logic [CFG_W-1:0] up_q, down_q, wu_q, wd_q, rec_q, par_q, convr_q, call_q;

	// sequencer state
	state_t            state_q;
	logic [PH_W-1:0]   ph_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] lvl_q;
	logic [ADDR_W-1:0] n_q;
	logic              leaf_q;
	logic              sat_q;
	logic              out_valid_q;

	// datapath registers
	logic [PRICE_W-1:0] spot_q;
	logic [POW_W-1:0]   upow_q, dpow_q;
	logic [PRICE_W-1:0] s_q, conv_q, vu_q, vd_q, sum_q, vcur_q, res_q;
	out_beat_t          out_data_q;

	// shared multiplier
	mul_cmd_t         mul_cmd;
	logic [MUL_W-1:0] op_a, op_b;
	mul_res_t         mres;

	// row memories
	logic              up_we, dn_we, val_we, up_re, dn_re, val_re;
	logic [ADDR_W-1:0] up_waddr, dn_waddr, val_waddr, up_raddr, dn_raddr, val_raddr;
	logic [POW_W-1:0]  up_wdata, dn_wdata, up_rdata, dn_rdata;
	logic [PRICE_W-1:0] val_wdata, val_rdata;

	logic               accept, out_load, node_done, sat_hit;
	logic [ADDR_W-1:0]  n_clamped;
	logic [PRICE_W:0]   sum33, tot33;
	logic [PRICE_W-1:0] tot_sat, capped, node_v, leaf_v;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// more levels than the rows hold fall back to the full depth
	assign n_clamped = (in_data.step_count > STEP_W'(MAX_STEPS)) ? ADDR_W'(MAX_STEPS)
	                                                             : ADDR_W'(in_data.step_count);

	// node combine: weighted sum, recovery add, call cap, conversion floor
	assign sum33   = {1'b0, vu_q} + {1'b0, vd_q};
	assign tot33   = {1'b0, sum_q} + {1'b0, rec_q};
	assign tot_sat = tot33[PRICE_W] ? {PRICE_W{1'b1}} : tot33[PRICE_W-1:0];
	assign capped  = (tot_sat > call_q) ? call_q : tot_sat;
	assign node_v  = (capped < conv_q) ? conv_q : capped;
	assign leaf_v  = (conv_q > par_q) ? conv_q : par_q;

	assign node_done = leaf_q ? (ph_q == PH_VU) : (ph_q == PH_WB);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= UP_RST;
			down_q  <= DOWN_RST;
			wu_q    <= '0;
			wd_q    <= '0;
			rec_q   <= '0;
			par_q   <= PAR_RST;
			convr_q <= CONV_RST;
			call_q  <= CALL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				REG_UP_FACTOR:        up_q    <= cfg_data;
				REG_DOWN_FACTOR:      down_q  <= cfg_data;
				REG_WEIGHT_UP:        wu_q    <= cfg_data;
				REG_WEIGHT_DOWN:      wd_q    <= cfg_data;
				REG_RECOVERY_TERM:    rec_q   <= cfg_data;
				REG_PAR_AMOUNT:       par_q   <= cfg_data;
				REG_CONVERSION_RATIO: convr_q <= cfg_data;
				REG_CALL_PRICE:       call_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// multiplier operand selection and take-out format
	always_comb begin
		mul_cmd = '{go: 1'b0, add_hi: 1'b0, sh: SH_30, cap64: 1'b0};
		op_a    = '0;
		op_b    = '0;
		case (state_q)
			ST_POW: begin
				// power table saturates at the full 64-bit range
				mul_cmd.cap64 = 1'b1;
				case (ph_q)
					PW_U_LO: begin
						mul_cmd.go = 1'b1;
						op_a = upow_q[MUL_W-1:0];
						op_b = up_q;
					end
					PW_U_HI: begin
						mul_cmd.go     = 1'b1;
						mul_cmd.add_hi = 1'b1;
						op_a = upow_q[POW_W-1:MUL_W];
						op_b = up_q;
					end
					PW_D_LO: begin
						mul_cmd.go = 1'b1;
						op_a = dpow_q[MUL_W-1:0];
						op_b = down_q;
					end
					PW_D_HI: begin
						mul_cmd.go     = 1'b1;
						mul_cmd.add_hi = 1'b1;
						op_a = dpow_q[POW_W-1:MUL_W];
						op_b = down_q;
					end
					default: ;
				endcase
			end
			ST_NODE: begin
				case (ph_q)
					PH_SD_LO: begin
						mul_cmd.go = 1'b1;
						op_a = spot_q;
						op_b = dn_rdata[MUL_W-1:0];
					end
					PH_SD_HI: begin
						mul_cmd.go     = 1'b1;
						mul_cmd.add_hi = 1'b1;
						op_a = spot_q;
						op_b = dn_rdata[POW_W-1:MUL_W];
					end
					PH_SU_LO: begin
						mul_cmd.go = 1'b1;
						op_a = s_q;
						op_b = up_rdata[MUL_W-1:0];
					end
					PH_SU_HI: begin
						mul_cmd.go     = 1'b1;
						mul_cmd.add_hi = 1'b1;
						op_a = s_q;
						op_b = up_rdata[POW_W-1:MUL_W];
					end
					PH_CONV: begin
						mul_cmd.go = 1'b1;
						op_a = s_q;
						op_b = convr_q;
					end
					PH_WUP: begin
						mul_cmd.go = !leaf_q;
						op_a = val_rdata;
						op_b = wu_q;
					end
					PH_WDN: begin
						mul_cmd.go = !leaf_q;
						mul_cmd.sh = SH_16;
						op_a = vcur_q;
						op_b = wd_q;
					end
					PH_VU, PH_VD: mul_cmd.sh = SH_31;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// which cycles can clip a value
	always_comb begin
		sat_hit = 1'b0;
		case (state_q)
			ST_POW: begin
				if (ph_q == PW_D_HI || ph_q == PW_D_TAKE) begin
					sat_hit = mres.ovf;
				end
			end
			ST_NODE: begin
				case (ph_q)
					PH_SD_TAKE, PH_SU_TAKE, PH_WDN: sat_hit = mres.ovf;
					PH_VU, PH_VD:                   sat_hit = mres.ovf && !leaf_q;
					PH_SUM:                         sat_hit = sum33[PRICE_W];
					PH_WB:                          sat_hit = tot33[PRICE_W];
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// power tables: entry 0 is one, then one entry per step
	assign up_we    = (state_q == ST_POW_INIT) || (state_q == ST_POW && ph_q == PW_D_HI);
	assign up_waddr = (state_q == ST_POW_INIT) ? '0 : j_q;
	assign up_wdata = (state_q == ST_POW_INIT) ? ONE_Q30 : mres.value;
	assign up_re    = (state_q == ST_NODE) && (ph_q == PH_RD);
	assign up_raddr = j_q;

	assign dn_we    = (state_q == ST_POW_INIT) || (state_q == ST_POW && ph_q == PW_D_TAKE);
	assign dn_waddr = (state_q == ST_POW_INIT) ? '0 : j_q;
	assign dn_wdata = (state_q == ST_POW_INIT) ? ONE_Q30 : mres.value;
	assign dn_re    = up_re;
	assign dn_raddr = lvl_q - j_q;

	// value row is updated in place: each node reads only its upper child,
	// the lower child is carried over from the previous node
	assign val_re    = ((state_q == ST_LVL_START) && (ph_q == LS_RD))
	                || ((state_q == ST_NODE) && (ph_q == PH_RD) && !leaf_q);
	assign val_raddr = (state_q == ST_NODE) ? (j_q + ADDR_W'(1)) : '0;
	assign val_we    = (state_q == ST_NODE) && node_done;
	assign val_waddr = j_q;
	assign val_wdata = leaf_q ? leaf_v : node_v;

	cblp_ram #(.WIDTH(POW_W), .DEPTH(ROW_DEPTH)) u_up_pow (
		.clk     (clk),
		.wr_en   (up_we),
		.wr_addr (up_waddr),
		.wr_data (up_wdata),
		.rd_en   (up_re),
		.rd_addr (up_raddr),
		.rd_data (up_rdata)
	);

	cblp_ram #(.WIDTH(POW_W), .DEPTH(ROW_DEPTH)) u_dn_pow (
		.clk     (clk),
		.wr_en   (dn_we),
		.wr_addr (dn_waddr),
		.wr_data (dn_wdata),
		.rd_en   (dn_re),
		.rd_addr (dn_raddr),
		.rd_data (dn_rdata)
	);

	cblp_ram #(.WIDTH(PRICE_W), .DEPTH(ROW_DEPTH)) u_value_row (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (val_waddr),
		.wr_data (val_wdata),
		.rd_en   (val_re),
		.rd_addr (val_raddr),
		.rd_data (val_rdata)
	);

	cblp_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.op_a   (op_a),
		.op_b   (op_b),
		.res    (mres)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= '0;
			j_q         <= '0;
			lvl_q       <= '0;
			n_q         <= '0;
			leaf_q      <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// clip flag restarts with each accepted request
			sat_q <= accept ? 1'b0 : (sat_q | sat_hit);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= n_clamped;
						state_q <= ST_POW_INIT;
					end
				end
				ST_POW_INIT: begin
					ph_q <= '0;
					if (n_q == '0) begin
						// zero steps: the root is the only leaf
						lvl_q   <= '0;
						leaf_q  <= 1'b1;
						j_q     <= '0;
						state_q <= ST_NODE;
					end else begin
						j_q     <= ADDR_W'(1);
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (ph_q == PW_D_TAKE) begin
						ph_q <= '0;
						if (j_q == n_q) begin
							lvl_q   <= n_q;
							leaf_q  <= 1'b1;
							j_q     <= '0;
							state_q <= ST_NODE;
						end else begin
							j_q <= j_q + ADDR_W'(1);
						end
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				ST_LVL_START: begin
					if (ph_q == LS_TAKE) begin
						ph_q    <= '0;
						state_q <= ST_NODE;
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				ST_NODE: begin
					if (node_done) begin
						ph_q <= '0;
						if (j_q == lvl_q) begin
							if (lvl_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								lvl_q   <= lvl_q - ADDR_W'(1);
								leaf_q  <= 1'b0;
								j_q     <= '0;
								state_q <= ST_LVL_START;
							end
						end else begin
							j_q <= j_q + ADDR_W'(1);
						end
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// a new result replaces one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		if (accept) begin
			spot_q <= in_data.spot_price;
		end
		case (state_q)
			ST_POW_INIT: begin
				upow_q <= ONE_Q30;
				dpow_q <= ONE_Q30;
			end
			ST_POW: begin
				case (ph_q)
					PW_D_HI:   upow_q <= mres.value;
					PW_D_TAKE: dpow_q <= mres.value;
					default: ;
				endcase
			end
			ST_LVL_START: begin
				if (ph_q == LS_TAKE) begin
					vcur_q <= val_rdata;
				end
			end
			ST_NODE: begin
				case (ph_q)
					PH_SD_TAKE, PH_SU_TAKE: s_q <= mres.value[PRICE_W-1:0];
					PH_WDN:  conv_q <= mres.value[PRICE_W-1:0];
					PH_VU: begin
						if (leaf_q) begin
							res_q <= leaf_v;
						end else begin
							vu_q <= mres.value[PRICE_W-1:0];
						end
					end
					PH_VD:   vd_q  <= mres.value[PRICE_W-1:0];
					PH_SUM:  sum_q <= sum33[PRICE_W] ? {PRICE_W{1'b1}} : sum33[PRICE_W-1:0];
					PH_WB: begin
						res_q  <= node_v;
						vcur_q <= val_rdata;
					end
					default: ;
				endcase
			end
			ST_FINISH: begin
				if (out_load) begin
					out_data_q <= '{bond_value: res_q, saturated: sat_q};
				end
			end
			default: ;
		endcase
	end

	// busy straight after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while a pricing is already running");

	// no row memory writes while idle
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(up_we || dn_we || val_we))
		else $error("row memory written while idle");

	// node index stays inside the current level, level inside the request depth
	a_node_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE) |-> (j_q <= lvl_q) && (lvl_q <= n_q))
		else $error("node index outside the lattice");

	// a result only appears after the root node is done
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result beat raised outside the finish step");

	// interior levels are only entered after their row head was preloaded
	a_level_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE && $past(state_q) == ST_LVL_START) |-> !leaf_q && (j_q == '0))
		else $error("interior level started without a fresh row head");

endmodule
